>>> design/ren_pkg.sv
// Shared types and constants for the Raft election node.
// Holds the event, result and vote-store write structs used by the design modules.
// No dependencies.
`default_nettype none

package ren_pkg;

   localparam int TERM_W     = 10;
   localparam int NODE_W     = 4;
   localparam int INDEX_W    = 16;
   localparam int COUNT_W    = 4;
   localparam int CSR_W      = 16;
   localparam int TERM_SLOTS = 1024;
   localparam int SLOT_W     = $clog2(TERM_SLOTS);

   localparam logic [TERM_W-1:0]  TERM_MAX  = {TERM_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef enum logic [1:0] {
      ROLE_FOLLOWER  = 2'd0,
      ROLE_CANDIDATE = 2'd1,
      ROLE_LEADER    = 2'd2
   } role_type;

   typedef enum logic [1:0] {
      KIND_VOTE_REQ  = 2'd0,
      KIND_VOTE_RSP  = 2'd1,
      KIND_HEARTBEAT = 2'd2,
      KIND_TIMEOUT   = 2'd3
   } msg_kind_type;

   typedef enum logic [1:0] {
      OUT_VOTE_REQ  = 2'd0,
      OUT_VOTE_RSP  = 2'd1,
      OUT_HEARTBEAT = 2'd2
   } out_kind_type;

   typedef enum logic [1:0] {
      CSR_SELF_ID    = 2'd0,
      CSR_PEER_COUNT = 2'd1,
      CSR_LAST_TERM  = 2'd2,
      CSR_LAST_INDEX = 2'd3
   } csr_index_type;

   typedef struct packed {
      msg_kind_type        kind;
      logic [NODE_W-1:0]   sender_node;
      logic [TERM_W-1:0]   msg_term;
      logic [TERM_W-1:0]   cand_last_term;
      logic [INDEX_W-1:0]  cand_last_index;
      logic                vote_granted;
   } event_type;

   typedef struct packed {
      out_kind_type        out_kind;
      logic [NODE_W-1:0]   dest_node;
      logic [TERM_W-1:0]   out_term;
      logic                out_granted;
      logic [TERM_W-1:0]   out_last_term;
      logic [INDEX_W-1:0]  out_last_index;
      logic [1:0]          role_now;
      logic [NODE_W-1:0]   leader_now;
   } result_type;

   typedef struct packed {
      logic               en;
      logic [SLOT_W-1:0]  slot;
   } vote_wr_type;

   // Slot of a term in the voted-term store (term modulo TERM_SLOTS).
   function automatic logic [SLOT_W-1:0] slot_of(input logic [TERM_W-1:0] term);
      return SLOT_W'(term);
   endfunction

endpackage

`default_nettype wire

>>> design/raft_election_node.sv
// Raft leader-election node: one event item in, at most one message item out.
// An accepted item is registered together with its voted-term memory read;
// the decision is then registered into the output register.
// Throughput: one item per cycle; a result waiting with rsp_tready low holds
// req_tready low once the next item also has a result. Reset is synchronous;
// afterwards the voted-term memory is swept clear, req_tready low.
`default_nettype none

module raft_election_node
   import ren_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   // sender_node[3:0], msg_term[13:4], cand_last_term[23:14],
   // cand_last_index[39:24], vote_granted[40], zero[47:41]
   input  wire logic [47:0]       req_tdata,
   // req_type[1:0]
   input  wire logic [1:0]        req_tuser,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   // dest_node[3:0], out_term[13:4], out_granted[14], out_last_term[24:15],
   // out_last_index[40:25], role_now[42:41], leader_now[46:43], zero[47]
   output logic [47:0]            rsp_tdata,
   // out_kind[1:0]
   output logic [1:0]             rsp_tuser,
   input  wire logic              csr_wr_en,
   input  wire logic [1:0]        csr_index,
   input  wire logic [CSR_W-1:0]  csr_wdata
);

   event_type    evt_ff, evt_in;
   logic         evt_valid_ff;
   result_type   res;
   logic         res_valid;
   result_type   rsp_ff;
   logic         rsp_valid_ff;
   vote_wr_type  wr;
   logic         voted;
   logic         clear_busy;
   logic         stall;
   logic         accept;
   logic         fire;

   assign evt_in.kind            = msg_kind_type'(req_tuser);
   assign evt_in.sender_node     = req_tdata[3:0];
   assign evt_in.msg_term        = req_tdata[13:4];
   assign evt_in.cand_last_term  = req_tdata[23:14];
   assign evt_in.cand_last_index = req_tdata[39:24];
   assign evt_in.vote_granted    = req_tdata[40];

   // Hold the stage when its result cannot enter the output register.
   assign stall      = evt_valid_ff && res_valid && rsp_valid_ff && !rsp_tready;
   assign req_tready = !clear_busy && !stall;
   assign accept     = req_tvalid && req_tready;
   assign fire       = evt_valid_ff && !stall;

   ren_vote_store u_store (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (accept),
      .rd_slot    (slot_of(evt_in.msg_term)),
      .wr         (wr),
      .rd_voted   (voted),
      .clear_busy (clear_busy)
   );

   ren_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .evt       (evt_ff),
      .evt_valid (evt_valid_ff),
      .evt_fire  (fire),
      .voted     (voted),
      .res       (res),
      .res_valid (res_valid),
      .wr        (wr)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         evt_valid_ff <= 1'b0;
      end else if (!stall) begin
         evt_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         evt_ff <= evt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire && res_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.out_kind;
   assign rsp_tdata  = {1'b0, rsp_ff.leader_now, rsp_ff.role_now, rsp_ff.out_last_index,
                        rsp_ff.out_last_term, rsp_ff.out_granted, rsp_ff.out_term,
                        rsp_ff.dest_node};

   a_heartbeat_from_leader: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == OUT_HEARTBEAT) |-> rsp_tdata[42:41] == ROLE_LEADER)
      else $error("heartbeat sent while not leader");

   a_vote_req_from_candidate: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == OUT_VOTE_REQ) |-> rsp_tdata[42:41] == ROLE_CANDIDATE)
      else $error("vote request sent while not candidate");

   a_grant_only_in_response: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[14] |-> rsp_tuser == OUT_VOTE_RSP)
      else $error("granted flag outside a vote response");

   a_no_work_during_clear: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !evt_valid_ff && !wr.en)
      else $error("event processed during memory clear");

endmodule

`default_nettype wire

>>> design/ren_vote_store.sv
// Voted-term store: one bit per term slot in a synchronous memory.
// Sweeps the memory clear after reset; forwards a same-cycle write to the read.
// Depends on ren_pkg.
`default_nettype none

module ren_vote_store
   import ren_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              rd_en,
   input  wire logic [SLOT_W-1:0] rd_slot,
   input  wire vote_wr_type       wr,
   output logic                   rd_voted,
   output logic                   clear_busy
);

   logic               voted_mem [TERM_SLOTS];
   logic               rd_voted_ff;
   logic [SLOT_W-1:0]  clr_slot_ff;
   logic [SLOT_W-1:0]  clr_slot_in;
   logic               clear_busy_ff;
   logic               clear_busy_in;
   logic               fwd_hit;

   assign fwd_hit = wr.en && (wr.slot == rd_slot);

   always_comb begin
      clr_slot_in   = clr_slot_ff;
      clear_busy_in = clear_busy_ff;
      if (clear_busy_ff) begin
         clr_slot_in = clr_slot_ff + 1'b1;
         if (clr_slot_ff == SLOT_W'(TERM_SLOTS - 1)) begin
            clear_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_slot_ff   <= '0;
         clear_busy_ff <= 1'b1;
      end else begin
         clr_slot_ff   <= clr_slot_in;
         clear_busy_ff <= clear_busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clear_busy_ff) begin
         voted_mem[clr_slot_ff] <= 1'b0;
      end else if (wr.en) begin
         voted_mem[wr.slot] <= 1'b1;
      end
   end

   // Old data comes out of the array on a collision; take the new bit instead.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_voted_ff <= voted_mem[rd_slot] | fwd_hit;
      end
   end

   assign rd_voted   = rd_voted_ff;
   assign clear_busy = clear_busy_ff;

endmodule

`default_nettype wire

>>> design/ren_ctrl.sv
// Election control: role, term, leader, retry flag, grant count and config.
// Decides each event against the voted bit and issues the vote-store write.
// Depends on ren_pkg.
`default_nettype none

module ren_ctrl
   import ren_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_wr_en,
   input  wire logic [1:0]        csr_index,
   input  wire logic [CSR_W-1:0]  csr_wdata,
   input  wire event_type         evt,
   input  wire logic              evt_valid,
   input  wire logic              evt_fire,
   input  wire logic              voted,
   output result_type             res,
   output logic                   res_valid,
   output vote_wr_type            wr
);

   logic [NODE_W-1:0]   self_id_ff;
   logic [COUNT_W-1:0]  peer_count_ff;
   logic [TERM_W-1:0]   own_term_ff;
   logic [INDEX_W-1:0]  own_index_ff;

   role_type            role_ff, role_in;
   logic [TERM_W-1:0]   term_ff, term_in;
   logic [NODE_W-1:0]   leader_ff, leader_in;
   logic                retry_ff, retry_in;
   logic [COUNT_W-1:0]  grants_ff, grants_in;
   logic                log_ok;

   assign log_ok = (evt.cand_last_term > own_term_ff) ||
                   ((evt.cand_last_term == own_term_ff) &&
                    (evt.cand_last_index >= own_index_ff));

   always_comb begin
      role_in   = role_ff;
      term_in   = term_ff;
      leader_in = leader_ff;
      retry_in  = retry_ff;
      grants_in = grants_ff;
      res_valid = 1'b0;
      wr        = '0;
      res       = '0;
      case (role_ff)
         ROLE_LEADER: begin
            if (evt.kind == KIND_TIMEOUT) begin
               res_valid    = 1'b1;
               res.out_kind = OUT_HEARTBEAT;
            end
         end
         ROLE_CANDIDATE: begin
            case (evt.kind)
               KIND_VOTE_RSP: begin
                  if (evt.vote_granted) begin
                     if (grants_ff != COUNT_MAX) begin
                        grants_in = grants_ff + 1'b1;
                     end
                     if (grants_in >= (peer_count_ff >> 1)) begin
                        role_in   = ROLE_LEADER;
                        leader_in = self_id_ff;
                        retry_in  = 1'b0;
                     end
                  end else if (evt.msg_term > term_ff) begin
                     role_in  = ROLE_FOLLOWER;
                     term_in  = evt.msg_term;
                     retry_in = 1'b0;
                  end
               end
               KIND_HEARTBEAT: begin
                  if (evt.msg_term >= term_ff) begin
                     role_in   = ROLE_FOLLOWER;
                     term_in   = evt.msg_term;
                     leader_in = evt.sender_node;
                     retry_in  = 1'b0;
                  end
               end
               KIND_TIMEOUT: begin
                  // Retry at the same term.
                  retry_in           = 1'b1;
                  grants_in          = '0;
                  wr.en              = 1'b1;
                  wr.slot            = slot_of(term_ff);
                  res_valid          = 1'b1;
                  res.out_kind       = OUT_VOTE_REQ;
                  res.out_last_term  = own_term_ff;
                  res.out_last_index = own_index_ff;
               end
               default: begin
               end
            endcase
         end
         default: begin
            role_in = ROLE_FOLLOWER;
            case (evt.kind)
               KIND_VOTE_REQ: begin
                  // Answer a request only while no vote is recorded for its term.
                  if (!voted) begin
                     res_valid       = 1'b1;
                     res.out_kind    = OUT_VOTE_RSP;
                     res.dest_node   = evt.sender_node;
                     res.out_granted = log_ok;
                     wr.en           = log_ok;
                     wr.slot         = slot_of(evt.msg_term);
                  end
               end
               KIND_HEARTBEAT: begin
                  if (evt.msg_term >= term_ff) begin
                     term_in   = evt.msg_term;
                     leader_in = evt.sender_node;
                  end
               end
               KIND_TIMEOUT: begin
                  role_in = ROLE_CANDIDATE;
                  if (!retry_ff && (term_ff != TERM_MAX)) begin
                     term_in = term_ff + 1'b1;
                  end
                  grants_in          = '0;
                  wr.en              = 1'b1;
                  wr.slot            = slot_of(term_in);
                  res_valid          = 1'b1;
                  res.out_kind       = OUT_VOTE_REQ;
                  res.out_last_term  = own_term_ff;
                  res.out_last_index = own_index_ff;
               end
               default: begin
               end
            endcase
         end
      endcase
      res.out_term   = term_in;
      res.role_now   = role_in;
      res.leader_now = leader_in;
      // Nothing happens without a live event in the stage.
      if (!evt_valid) begin
         res_valid = 1'b0;
      end
      if (!evt_fire) begin
         wr.en = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         role_ff   <= ROLE_FOLLOWER;
         term_ff   <= '0;
         leader_ff <= '0;
         retry_ff  <= 1'b0;
         grants_ff <= '0;
      end else if (evt_fire) begin
         role_ff   <= role_in;
         term_ff   <= term_in;
         leader_ff <= leader_in;
         retry_ff  <= retry_in;
         grants_ff <= grants_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         self_id_ff    <= '0;
         peer_count_ff <= COUNT_W'(4);
         own_term_ff   <= '0;
         own_index_ff  <= '0;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_SELF_ID:    self_id_ff    <= csr_wdata[NODE_W-1:0];
            CSR_PEER_COUNT: peer_count_ff <= csr_wdata[COUNT_W-1:0];
            CSR_LAST_TERM:  own_term_ff   <= csr_wdata[TERM_W-1:0];
            CSR_LAST_INDEX: own_index_ff  <= csr_wdata[INDEX_W-1:0];
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire
